FILE: src/timer_deadline_queue_core_macros.svh
// Assertion macros for the timer deadline queue checker.
// Needs clk and rst_n in the scope of each use; no other dependencies.
`ifndef TIMER_DEADLINE_QUEUE_CORE_MACROS_SVH
`define TIMER_DEADLINE_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TDQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tdq_pkg.sv
// Shared types and codes for the timer deadline queue.
// No dependencies; used by the core, its compare unit and the checker.
package tdq_pkg;

    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CANCEL = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_EXPIRE = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

    // Result of comparing the operation key against one stored entry.
    typedef struct packed {
        logic ahead;    // key sorts ahead of the entry
        logic match;    // handles are equal
        logic due;      // entry deadline at or before key time
    } cmp_flags_t;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_INS      = 7'b0000010,
        S_PLACE    = 7'b0000100,
        S_CAN      = 7'b0001000,
        S_EXP_SCAN = 7'b0010000,
        S_EXP_EMIT = 7'b0100000,
        S_RESP     = 7'b1000000
    } state_t;

endpackage

FILE: src/tdq_compare.sv
// Key-versus-entry comparator of the timer deadline queue.
// Depends on tdq_pkg for cmp_flags_t.
module tdq_compare import tdq_pkg::*; #(
    parameter int TIME_BITS   = 48,
    parameter int HANDLE_BITS = 8
) (
    input  logic [TIME_BITS-1:0]   key_time,
    input  logic [HANDLE_BITS-1:0] key_handle,
    input  logic [TIME_BITS-1:0]   ent_time,
    input  logic [HANDLE_BITS-1:0] ent_handle,
    output cmp_flags_t             flags
);

    logic time_lt;
    logic time_eq;

    assign time_lt = key_time < ent_time;
    assign time_eq = key_time == ent_time;

    // ties on deadline go by ascending handle
    assign flags.ahead = time_lt || (time_eq && (key_handle < ent_handle));
    assign flags.match = key_handle == ent_handle;
    assign flags.due   = !time_lt;

endmodule

FILE: src/timer_deadline_queue_core.sv
// Sorted timer queue: top level, slot memory and operation sequencer.
// Depends on tdq_pkg and tdq_compare.
//
// Usage
// - Command channel: drive opcode, time_value and timer_handle with start
//   high; the beat is taken on a clock edge where busy is low. opcode 0
//   inserts (time_value is the deadline), 1 cancels timer_handle, 2 expires
//   every timer due at or before time_value, 3 does nothing.
// - Result channel: each result beat sits on the result ports for one cycle
//   with result_valid high. The receiver cannot stall; beats come whether or
//   not anyone looks. An expire that hits n timers sends n back-to-back beats
//   in deadline order, last_result on the final one; every other case sends
//   exactly one beat with last_result high.
// - Timing: one slot read per cycle sets the pace. A no-op, a full insert or
//   an empty cancel or expire goes straight to the result. A cancel reads
//   every entry; an insert reads from the tail back to its slot, or places
//   at once into an empty queue; an expire reads from the head to the first
//   entry not due, then, if any were due, sends the beats first, then the
//   survivors move up. A single beat shows in the first cycle with busy low,
//   where the next command may already be taken.
// - Reset: rst_n clears the entry count, so the queue starts empty with no
//   memory clearing pass; slot contents are only read below the count.
module timer_deadline_queue_core import tdq_pkg::*; #(
    parameter int QUEUE_DEPTH = 32,
    parameter int TIME_BITS   = 48,
    parameter int HANDLE_BITS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // command
    input  logic                   start,
    output logic                   busy,
    input  logic [OPCODE_W-1:0]    opcode,
    input  logic [TIME_BITS-1:0]   time_value,
    input  logic [HANDLE_BITS-1:0] timer_handle,
    // result
    output logic                   result_valid,
    output logic                   expired_valid,
    output logic [HANDLE_BITS-1:0] expired_handle,
    output logic                   last_result,
    output logic                   earliest_changed,
    output logic [STATUS_W-1:0]    status_code,
    output logic                   queue_empty,
    output logic [TIME_BITS-1:0]   next_deadline
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W = TIME_BITS + HANDLE_BITS;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    // ------------------------------------------------------------------
    // Slot memory: {deadline, handle} per slot, sorted, slot 0 earliest.
    // One write and one read port, read data registered.
    // ------------------------------------------------------------------
    logic [ENT_W-1:0] slot_mem [QUEUE_DEPTH];
    logic [ENT_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    logic [TIME_BITS-1:0]   dat_time;
    logic [HANDLE_BITS-1:0] dat_handle;

    assign dat_time   = rd_data_reg[ENT_W-1:HANDLE_BITS];
    assign dat_handle = rd_data_reg[HANDLE_BITS-1:0];

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;      // live entries
    logic [TIME_BITS-1:0]   head_reg, head_next;        // copy of slot 0 deadline
    logic [TIME_BITS-1:0]   key_time_reg, key_time_next;
    logic [HANDLE_BITS-1:0] key_handle_reg, key_handle_next;
    logic [CNT_W-1:0]       len_reg, len_next;          // entries at accept
    logic [CNT_W-1:0]       iss_reg, iss_next;          // read issue counter
    logic [CNT_W-1:0]       n_reg, n_next;              // expired count
    logic [IDX_W-1:0]       pos_reg, pos_next;          // insert slot
    logic                   found_reg, found_next;
    logic                   chg_reg, chg_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic                   rd_vld_reg;                 // rd_data_reg holds a slot
    logic [IDX_W-1:0]       rd_idx_reg;                 // ... namely this one
    logic                   issue;

    // result output registers
    logic                   out_valid_reg, out_valid_next;
    logic                   out_exp_reg, out_exp_next;
    logic [HANDLE_BITS-1:0] out_handle_reg, out_handle_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_chg_reg, out_chg_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic                   out_empty_reg, out_empty_next;
    logic [TIME_BITS-1:0]   out_deadline_reg, out_deadline_next;

    cmp_flags_t flags;

    tdq_compare #(
        .TIME_BITS   (TIME_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_compare (
        .key_time   (key_time_reg),
        .key_handle (key_handle_reg),
        .ent_time   (dat_time),
        .ent_handle (dat_handle),
        .flags      (flags)
    );

    logic             last_data;
    logic             stop_scan;
    logic [CNT_W-1:0] rd_idx_cnt;
    logic [CNT_W-1:0] n_final;

    assign rd_idx_cnt = CNT_W'(rd_idx_reg);
    assign last_data  = rd_idx_cnt == (len_reg - CNT_W'(1));
    assign n_final    = n_reg + CNT_W'(flags.due);

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        head_next         = head_reg;
        key_time_next     = key_time_reg;
        key_handle_next   = key_handle_reg;
        len_next          = len_reg;
        iss_next          = iss_reg;
        n_next            = n_reg;
        pos_next          = pos_reg;
        found_next        = found_reg;
        chg_next          = chg_reg;
        status_next       = status_reg;
        issue             = 1'b0;
        stop_scan         = 1'b0;
        rd_addr           = iss_reg[IDX_W-1:0];
        wr_en             = 1'b0;
        wr_addr           = rd_idx_reg;
        wr_data           = rd_data_reg;
        out_valid_next    = 1'b0;
        out_exp_next      = out_exp_reg;
        out_handle_next   = out_handle_reg;
        out_last_next     = out_last_reg;
        out_chg_next      = out_chg_reg;
        out_status_next   = out_status_reg;
        out_empty_next    = out_empty_reg;
        out_deadline_next = out_deadline_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_time_next   = time_value;
                    key_handle_next = timer_handle;
                    len_next        = count_reg;
                    iss_next        = '0;
                    n_next          = '0;
                    pos_next        = '0;
                    found_next      = 1'b0;
                    chg_next        = 1'b0;
                    status_next     = STAT_OK;
                    case (opcode)
                        OP_INSERT:
                        begin
                            if (count_reg == DEPTH_CNT)
                            begin
                                status_next = STAT_FULL;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                // only a strictly earlier deadline counts
                                chg_next   = (count_reg == '0) || (time_value < head_reg);
                                iss_next   = count_reg;
                                state_next = (count_reg == '0) ? S_PLACE : S_INS;
                            end
                        end
                        OP_CANCEL:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_NOT_FOUND;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                state_next = S_CAN;
                            end
                        end
                        OP_EXPIRE:
                        begin
                            state_next = (count_reg == '0) ? S_RESP : S_EXP_SCAN;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            // Walk down from the tail, moving each later entry up one slot.
            S_INS:
            begin
                stop_scan = rd_vld_reg && !flags.ahead;
                issue     = (iss_reg != '0) && !stop_scan;
                rd_addr   = IDX_W'(iss_reg - CNT_W'(1));
                if (issue)
                begin
                    iss_next = iss_reg - CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (flags.ahead)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = IDX_W'(rd_idx_cnt + CNT_W'(1));
                        if (rd_idx_reg == '0)
                        begin
                            pos_next   = '0;
                            state_next = S_PLACE;
                        end
                    end
                    else
                    begin
                        pos_next   = IDX_W'(rd_idx_cnt + CNT_W'(1));
                        state_next = S_PLACE;
                    end
                end
            end

            S_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = {key_time_reg, key_handle_reg};
                count_next = count_reg + CNT_W'(1);
                state_next = S_RESP;
            end

            // Find first matching handle, then pull the rest down one slot.
            S_CAN:
            begin
                issue = iss_reg < len_reg;
                if (issue)
                begin
                    iss_next = iss_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (found_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = rd_idx_reg - IDX_W'(1);
                    end
                    else if (flags.match)
                    begin
                        found_next = 1'b1;
                    end
                    if (last_data)
                    begin
                        state_next = S_RESP;
                        if (found_reg || flags.match)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            status_next = STAT_NOT_FOUND;
                        end
                    end
                end
            end

            // Count due entries from the head; stops at the first later one.
            S_EXP_SCAN:
            begin
                stop_scan = rd_vld_reg && (!flags.due || last_data);
                issue     = (iss_reg < len_reg) && !stop_scan;
                if (issue)
                begin
                    iss_next = iss_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    n_next = n_final;
                end
                if (stop_scan)
                begin
                    if (n_final == '0)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        count_next = len_reg - n_final;
                        if (!flags.due)
                        begin
                            head_next = dat_time;
                        end
                        iss_next   = '0;
                        state_next = S_EXP_EMIT;
                    end
                end
            end

            // Emit the due handles, then compact the survivors to slot 0.
            S_EXP_EMIT:
            begin
                issue = iss_reg < len_reg;
                if (issue)
                begin
                    iss_next = iss_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (rd_idx_cnt < n_reg)
                    begin
                        out_valid_next    = 1'b1;
                        out_exp_next      = 1'b1;
                        out_handle_next   = dat_handle;
                        out_last_next     = rd_idx_cnt == (n_reg - CNT_W'(1));
                        out_chg_next      = 1'b0;
                        out_status_next   = STAT_OK;
                        out_empty_next    = count_reg == '0;
                        out_deadline_next = (count_reg == '0) ? '0 : head_reg;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = IDX_W'(rd_idx_cnt - n_reg);
                    end
                    if (last_data)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_RESP:
            begin
                out_valid_next    = 1'b1;
                out_exp_next      = 1'b0;
                out_handle_next   = '0;
                out_last_next     = 1'b1;
                out_chg_next      = chg_reg;
                out_status_next   = status_reg;
                out_empty_next    = count_reg == '0;
                out_deadline_next = (count_reg == '0) ? '0 : head_reg;
                state_next        = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // keep the head copy in step with slot 0
        if (wr_en && (wr_addr == '0))
        begin
            head_next = wr_data[ENT_W-1:HANDLE_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            len_reg       <= '0;
            iss_reg       <= '0;
            n_reg         <= '0;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            chg_reg       <= 1'b0;
            status_reg    <= STAT_OK;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            len_reg       <= len_next;
            iss_reg       <= iss_next;
            n_reg         <= n_next;
            pos_reg       <= pos_next;
            found_reg     <= found_next;
            chg_reg       <= chg_next;
            status_reg    <= status_next;
            rd_vld_reg    <= issue;
            rd_idx_reg    <= rd_addr;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg         <= head_next;
        key_time_reg     <= key_time_next;
        key_handle_reg   <= key_handle_next;
        out_exp_reg      <= out_exp_next;
        out_handle_reg   <= out_handle_next;
        out_last_reg     <= out_last_next;
        out_chg_reg      <= out_chg_next;
        out_status_reg   <= out_status_next;
        out_empty_reg    <= out_empty_next;
        out_deadline_reg <= out_deadline_next;
    end

    assign busy             = state_reg != S_IDLE;
    assign result_valid     = out_valid_reg;
    assign expired_valid    = out_exp_reg;
    assign expired_handle   = out_handle_reg;
    assign last_result      = out_last_reg;
    assign earliest_changed = out_chg_reg;
    assign status_code      = out_status_reg;
    assign queue_empty      = out_empty_reg;
    assign next_deadline    = out_deadline_reg;

endmodule

FILE: src/tdq_checker.sv
// Port-level checker for the timer deadline queue, bound to the top level.
// Depends on tdq_pkg and timer_deadline_queue_core_macros.svh.
`include "timer_deadline_queue_core_macros.svh"

module tdq_checker import tdq_pkg::*; #(
    parameter int TIME_BITS   = 48,
    parameter int HANDLE_BITS = 8
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   result_valid,
    input logic                   expired_valid,
    input logic [HANDLE_BITS-1:0] expired_handle,
    input logic                   last_result,
    input logic                   earliest_changed,
    input logic [STATUS_W-1:0]    status_code,
    input logic                   queue_empty,
    input logic [TIME_BITS-1:0]   next_deadline
);

    // every accepted command makes the core busy on the next cycle
    `TDQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")

    // an expire run is contiguous: a non-final beat is followed by an expired beat
    `TDQ_ASSERT_NEXT(a_run_gapless, result_valid && !last_result, result_valid && expired_valid, "gap inside expire run")

    `TDQ_ASSERT_NOW(a_plain_final, result_valid && !expired_valid, last_result && (expired_handle == '0), "non-expire beat not final or handle not zero")

    `TDQ_ASSERT_NOW(a_empty_zero, result_valid && queue_empty, next_deadline == '0, "empty queue with nonzero deadline")

    `TDQ_ASSERT_NOW(a_changed_ok, result_valid && earliest_changed, (status_code == STAT_OK) && !queue_empty && !expired_valid, "earliest change on a failed or non-insert beat")

endmodule

bind timer_deadline_queue_core tdq_checker #(
    .TIME_BITS   (TIME_BITS),
    .HANDLE_BITS (HANDLE_BITS)
) u_tdq_checker (.*);
